@@ rtl/nearest_palette_color_match_defines.svh @@
// Assertion helpers used by the top-level RTL.
`ifndef NEAREST_PALETTE_COLOR_MATCH_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_MATCH_DEFINES_SVH

// Same-cycle implication.
`define NPCM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("npcm assertion failed");

// Next-cycle implication.
`define NPCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("npcm assertion failed");

`endif

@@ rtl/npcm_pkg.sv @@
package npcm_pkg;

  localparam int unsigned PALETTE_DEPTH_DEF = 256;
  localparam int unsigned INDEX_SLOTS       = 256;

  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned WEIGHT_W = 10;
  localparam int unsigned SQ_W     = 2 * COLOR_W;
  localparam int unsigned PROD_W   = WEIGHT_W + SQ_W;
  localparam int unsigned DIST_W   = 28;
  localparam int unsigned RGB_W    = 3 * COLOR_W;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [COUNT_W-1:0]  COUNT_RST = 9'd0;
  localparam logic [WEIGHT_W-1:0] WR_RST    = 10'd299;
  localparam logic [WEIGHT_W-1:0] WG_RST    = 10'd587;
  localparam logic [WEIGHT_W-1:0] WB_RST    = 10'd114;

  typedef enum logic [1:0] {
    REG_COUNT = 2'd0,
    REG_WR    = 2'd1,
    REG_WG    = 2'd2,
    REG_WB    = 2'd3
  } reg_idx_e;

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [INDEX_W-1:0] entry_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } in_word_t;

  typedef struct packed {
    logic [INDEX_W-1:0] match_index;
    logic [COLOR_W-1:0] match_red;
    logic [COLOR_W-1:0] match_green;
    logic [COLOR_W-1:0] match_blue;
    logic [DIST_W-1:0]  match_distance;
    logic               no_match;
  } out_word_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] wr;
    logic [WEIGHT_W-1:0] wg;
    logic [WEIGHT_W-1:0] wb;
  } weights_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    weights_t           w;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [INDEX_W-1:0] idx;
    logic [RGB_W-1:0]   color;
  } cand_t;

  typedef struct packed {
    logic               valid;
    logic [INDEX_W-1:0] idx;
    logic [RGB_W-1:0]   color;
    logic [DIST_W-1:0]  distance;
  } dist_res_t;

endpackage

@@ rtl/npcm_regs.sv @@
module npcm_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [npcm_pkg::PADDR_W-1:0]      paddr,
  input  logic [npcm_pkg::PDATA_W-1:0]      pwdata,
  output logic [npcm_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  output npcm_pkg::cfg_t                    cfg_o
);

  logic [npcm_pkg::COUNT_W-1:0]  count_q;
  logic [npcm_pkg::WEIGHT_W-1:0] wr_q, wg_q, wb_q;
  logic                          wr_en;
  npcm_pkg::reg_idx_e            sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign sel    = npcm_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= npcm_pkg::COUNT_RST;
      wr_q    <= npcm_pkg::WR_RST;
      wg_q    <= npcm_pkg::WG_RST;
      wb_q    <= npcm_pkg::WB_RST;
    end else if (wr_en) begin
      case (sel)
        npcm_pkg::REG_COUNT: count_q <= pwdata[npcm_pkg::COUNT_W-1:0];
        npcm_pkg::REG_WR:    wr_q    <= pwdata[npcm_pkg::WEIGHT_W-1:0];
        npcm_pkg::REG_WG:    wg_q    <= pwdata[npcm_pkg::WEIGHT_W-1:0];
        npcm_pkg::REG_WB:    wb_q    <= pwdata[npcm_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      npcm_pkg::REG_COUNT: prdata = npcm_pkg::PDATA_W'(count_q);
      npcm_pkg::REG_WR:    prdata = npcm_pkg::PDATA_W'(wr_q);
      npcm_pkg::REG_WG:    prdata = npcm_pkg::PDATA_W'(wg_q);
      npcm_pkg::REG_WB:    prdata = npcm_pkg::PDATA_W'(wb_q);
      default:             prdata = '0;
    endcase
  end

  assign cfg_o.count = count_q;
  assign cfg_o.w.wr  = wr_q;
  assign cfg_o.w.wg  = wg_q;
  assign cfg_o.w.wb  = wb_q;

endmodule

@@ rtl/npcm_palette_mem.sv @@
module npcm_palette_mem #(
  parameter  int unsigned Depth = npcm_pkg::PALETTE_DEPTH_DEF,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AddrW-1:0]             waddr_i,
  input  logic [npcm_pkg::RGB_W-1:0]   wdata_i,
  input  logic                         re_i,
  input  logic [AddrW-1:0]             raddr_i,
  output logic [npcm_pkg::RGB_W-1:0]   rdata_o
);

  logic [npcm_pkg::RGB_W-1:0] mem_q [Depth];
  logic [npcm_pkg::RGB_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/npcm_dist.sv @@
module npcm_dist (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  npcm_pkg::cand_t               cand_i,
  input  logic [npcm_pkg::RGB_W-1:0]    pixel_i,
  input  npcm_pkg::weights_t            w_i,
  output npcm_pkg::dist_res_t           res_o,
  output logic                          busy_o
);

  localparam int unsigned CW = npcm_pkg::COLOR_W;
  localparam int unsigned SW = npcm_pkg::SQ_W;
  localparam int unsigned PW = npcm_pkg::PROD_W;
  localparam int unsigned DW = npcm_pkg::DIST_W;

  function automatic logic [SW-1:0] sq_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return {{CW{1'b0}}, d} * {{CW{1'b0}}, d};
  endfunction

  // stage 1: squared channel differences
  logic                        v1_q;
  logic [npcm_pkg::INDEX_W-1:0] idx1_q;
  logic [npcm_pkg::RGB_W-1:0]  col1_q;
  logic [SW-1:0]               sr1_q, sg1_q, sb1_q;
  // stage 2: weighted terms
  logic                        v2_q;
  logic [npcm_pkg::INDEX_W-1:0] idx2_q;
  logic [npcm_pkg::RGB_W-1:0]  col2_q;
  logic [PW-1:0]               pr2_q, pg2_q, pb2_q;
  // stage 3: sum
  logic                        v3_q;
  logic [npcm_pkg::INDEX_W-1:0] idx3_q;
  logic [npcm_pkg::RGB_W-1:0]  col3_q;
  logic [DW-1:0]               d3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cand_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= cand_i.idx;
    col1_q <= cand_i.color;
    sr1_q  <= sq_diff(cand_i.color[23:16], pixel_i[23:16]);
    sg1_q  <= sq_diff(cand_i.color[15:8],  pixel_i[15:8]);
    sb1_q  <= sq_diff(cand_i.color[7:0],   pixel_i[7:0]);

    idx2_q <= idx1_q;
    col2_q <= col1_q;
    pr2_q  <= {{SW{1'b0}}, w_i.wr} * {{npcm_pkg::WEIGHT_W{1'b0}}, sr1_q};
    pg2_q  <= {{SW{1'b0}}, w_i.wg} * {{npcm_pkg::WEIGHT_W{1'b0}}, sg1_q};
    pb2_q  <= {{SW{1'b0}}, w_i.wb} * {{npcm_pkg::WEIGHT_W{1'b0}}, sb1_q};

    idx3_q <= idx2_q;
    col3_q <= col2_q;
    d3_q   <= DW'(pr2_q) + DW'(pg2_q) + DW'(pb2_q);
  end

  assign res_o.valid    = v3_q;
  assign res_o.idx      = idx3_q;
  assign res_o.color    = col3_q;
  assign res_o.distance = d3_q;
  assign busy_o         = v1_q || v2_q || v3_q;

endmodule

@@ rtl/nearest_palette_color_match.sv @@
// Load word: written to the palette at its accept edge if its index is below the depth;
// a load may follow every cycle. Classify word: with n = min(palette_count, depth, 256)
// entries in use, the single palette read port scans one entry per cycle into the read
// register and distance pipeline; the next word can be accepted in the cycle after the
// result word is registered. Reset clears control state and restores the registers to
// their defaults; palette contents are not cleared and are undefined until written.
`include "nearest_palette_color_match_defines.svh"

module nearest_palette_color_match #(
  parameter int unsigned PALETTE_DEPTH = npcm_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  npcm_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output npcm_pkg::out_word_t           out_word_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [npcm_pkg::PADDR_W-1:0]  paddr,
  input  logic [npcm_pkg::PDATA_W-1:0]  pwdata,
  output logic [npcm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);
  localparam int unsigned NW = npcm_pkg::COUNT_W;
  localparam logic [NW-1:0] LIMIT = NW'((PALETTE_DEPTH < npcm_pkg::INDEX_SLOTS) ?
                                        PALETTE_DEPTH : npcm_pkg::INDEX_SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e                          state_q, state_d;
  npcm_pkg::cfg_t                  cfg;
  logic                            in_acc, do_load, do_class;
  logic [NW-1:0]                   used, n_q, issue_q;
  logic                            rd_en, rd_v_q;
  logic [npcm_pkg::INDEX_W-1:0]    rd_idx_q;
  logic [npcm_pkg::RGB_W-1:0]      rd_data, pix_q;
  npcm_pkg::cand_t                 cand;
  npcm_pkg::dist_res_t             dres;
  logic                            dist_busy;
  logic                            found_q, take;
  logic [npcm_pkg::INDEX_W-1:0]    best_idx_q;
  logic [npcm_pkg::RGB_W-1:0]      best_col_q;
  logic [npcm_pkg::DIST_W-1:0]     best_dist_q;
  logic                            out_valid_q, out_load;
  npcm_pkg::out_word_t             out_q;

  npcm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign do_load    = in_acc && (in_word_i.op == npcm_pkg::OP_LOAD) &&
                      (32'(in_word_i.entry_index) < 32'(PALETTE_DEPTH));
  assign do_class   = in_acc && (in_word_i.op == npcm_pkg::OP_CLASSIFY);
  assign used       = (cfg.count < LIMIT) ? cfg.count : LIMIT;
  assign rd_en      = (state_q == ST_SCAN) && (issue_q < n_q);

  npcm_palette_mem #(.Depth(PALETTE_DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (do_load),
    .waddr_i (AW'(in_word_i.entry_index)),
    .wdata_i ({in_word_i.red, in_word_i.green, in_word_i.blue}),
    .re_i    (rd_en),
    .raddr_i (AW'(issue_q[npcm_pkg::INDEX_W-1:0])),
    .rdata_o (rd_data)
  );

  assign cand.valid = rd_v_q;
  assign cand.idx   = rd_idx_q;
  assign cand.color = rd_data;

  npcm_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cand_i  (cand),
    .pixel_i (pix_q),
    .w_i     (cfg.w),
    .res_o   (dres),
    .busy_o  (dist_busy)
  );

  // later entry wins on equal distance
  assign take     = dres.valid && (!found_q || (dres.distance <= best_dist_q));
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (do_class) state_d = (used == '0) ? ST_DONE : ST_SCAN;
      ST_SCAN: if (!rd_en && !rd_v_q && !dist_busy) state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_q     <= '0;
      rd_v_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= rd_en;
      if (do_class) begin
        issue_q <= '0;
        found_q <= 1'b0;
      end else begin
        if (rd_en) issue_q <= issue_q + NW'(1);
        if (take) found_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_class) begin
      pix_q <= {in_word_i.red, in_word_i.green, in_word_i.blue};
      n_q   <= used;
    end
    rd_idx_q <= issue_q[npcm_pkg::INDEX_W-1:0];
    if (take) begin
      best_idx_q  <= dres.idx;
      best_col_q  <= dres.color;
      best_dist_q <= dres.distance;
    end
    if (out_load) begin
      if (found_q) begin
        out_q.match_index    <= best_idx_q;
        out_q.match_red      <= best_col_q[23:16];
        out_q.match_green    <= best_col_q[15:8];
        out_q.match_blue     <= best_col_q[7:0];
        out_q.match_distance <= best_dist_q;
        out_q.no_match       <= 1'b0;
      end else begin
        out_q          <= '0;
        out_q.no_match <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `NPCM_ASSERT_NOW(a_res_in_scan, dres.valid, state_q == ST_SCAN)
  `NPCM_ASSERT_NOW(a_done_drained, state_q == ST_DONE, !rd_v_q && !dist_busy)
  `NPCM_ASSERT_NOW(a_rise_from_done, $rose(out_valid_q), $past(state_q == ST_DONE))
  `NPCM_ASSERT_NOW(a_nomatch_zero, out_valid_q && out_q.no_match,
                   out_q.match_distance == '0 && out_q.match_index == '0)

endmodule

@@ tb/nearest_palette_color_match_tb.sv @@
`default_nettype none

module nearest_palette_color_match_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  logic                                clk_i;
  logic                                rst_n       = 1'b0;
  logic                                in_valid    = 1'b0;
  logic                                in_stall;
  npcm_pkg::in_word_t                  in_word     = '0;
  logic                                out_valid;
  logic                                out_stall   = 1'b0;
  npcm_pkg::out_word_t                 out_word;
  logic                                psel        = 1'b0;
  logic                                penable     = 1'b0;
  logic                                pwrite      = 1'b0;
  logic [npcm_pkg::PADDR_W-1:0]        paddr       = '0;
  logic [npcm_pkg::PDATA_W-1:0]        pwdata      = '0;
  logic [npcm_pkg::PDATA_W-1:0]        prdata;
  logic                                pready;

  // shadow of the block state
  logic [npcm_pkg::RGB_W-1:0]          palette_rgb [npcm_pkg::INDEX_SLOTS];
  logic [npcm_pkg::COUNT_W-1:0]        cfg_count = npcm_pkg::COUNT_RST;
  logic [npcm_pkg::WEIGHT_W-1:0]       cfg_wr    = npcm_pkg::WR_RST;
  logic [npcm_pkg::WEIGHT_W-1:0]       cfg_wg    = npcm_pkg::WG_RST;
  logic [npcm_pkg::WEIGHT_W-1:0]       cfg_wb    = npcm_pkg::WB_RST;

  npcm_pkg::out_word_t                 pending_matches [$];
  int unsigned                         mismatch_count = 0;
  int unsigned                         cycle_count    = 0;
  int unsigned                         gap_pct        = 30;
  int unsigned                         stall_pct      = 30;
  int unsigned                         stall_left     = 0;

  nearest_palette_color_match i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < npcm_pkg::INDEX_SLOTS; i++) palette_rgb[i] = '0;
  end

  function automatic int unsigned pick_gap(int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 8);
    return $urandom_range(3, 1);
  endfunction

  function automatic int unsigned used_entries();
    return (cfg_count > npcm_pkg::INDEX_SLOTS) ? npcm_pkg::INDEX_SLOTS : int'(cfg_count);
  endfunction

  function automatic int unsigned sq_diff(logic [npcm_pkg::COLOR_W-1:0] a,
                                          logic [npcm_pkg::COLOR_W-1:0] b);
    int unsigned d;
    d = (a >= b) ? a - b : b - a;
    return d * d;
  endfunction

  // nearest entry, later entry wins on equal distance
  function automatic npcm_pkg::out_word_t predict_nearest(npcm_pkg::in_word_t px);
    npcm_pkg::out_word_t        res;
    int unsigned                n;
    int unsigned                d;
    int unsigned                best;
    logic [npcm_pkg::RGB_W-1:0] c;
    res  = '0;
    best = 0;
    n    = used_entries();
    if (n == 0) begin
      res.no_match = 1'b1;
      return res;
    end
    for (int unsigned i = 0; i < n; i++) begin
      c = palette_rgb[i];
      d = cfg_wr * sq_diff(c[23:16], px.red) + cfg_wg * sq_diff(c[15:8], px.green)
        + cfg_wb * sq_diff(c[7:0], px.blue);
      if (i == 0 || d <= best) begin
        best = d;
        res.match_index = i[npcm_pkg::INDEX_W-1:0];
        {res.match_red, res.match_green, res.match_blue} = c;
      end
    end
    res.match_distance = best[npcm_pkg::DIST_W-1:0];
    return res;
  endfunction

  function automatic npcm_pkg::in_word_t make_word(npcm_pkg::op_e op, logic [7:0] idx,
                                                   logic [7:0] r, logic [7:0] g,
                                                   logic [7:0] b);
    npcm_pkg::in_word_t w;
    w.op          = op;
    w.entry_index = idx;
    w.red         = r;
    w.green       = g;
    w.blue        = b;
    return w;
  endfunction

  function automatic logic [7:0] near_channel(logic [7:0] c);
    int t;
    t = int'(c) + int'($urandom_range(6)) - 3;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[7:0];
  endfunction

  function automatic npcm_pkg::in_word_t random_word();
    npcm_pkg::in_word_t         w;
    int unsigned                n_used;
    logic [npcm_pkg::RGB_W-1:0] src;
    n_used = used_entries();
    w.op = ($urandom_range(99) < 45) ? npcm_pkg::OP_CLASSIFY : npcm_pkg::OP_LOAD;
    if (n_used != 0 && $urandom_range(3) != 0) w.entry_index = 8'($urandom_range(n_used - 1));
    else w.entry_index = 8'($urandom());
    src = palette_rgb[(n_used != 0) ? $urandom_range(n_used - 1) : $urandom_range(255)];
    case ($urandom_range(5))
      0: {w.red, w.green, w.blue} = src;
      1: {w.red, w.green, w.blue} = {near_channel(src[23:16]), near_channel(src[15:8]),
                                     near_channel(src[7:0])};
      2: {w.red, w.green, w.blue} = {($urandom_range(1) ? 8'hFF : 8'h00),
                                     ($urandom_range(1) ? 8'hFF : 8'h00),
                                     ($urandom_range(1) ? 8'hFF : 8'h00)};
      default: {w.red, w.green, w.blue} = 24'($urandom());
    endcase
    return w;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatch_count++;
    end
  endfunction

  function automatic void check_match(npcm_pkg::out_word_t got);
    npcm_pkg::out_word_t exp_w;
    if (pending_matches.size() == 0) begin
      $error("unexpected result word: index %0d distance %0d", got.match_index,
             got.match_distance);
      mismatch_count++;
      return;
    end
    exp_w = pending_matches.pop_front();
    check_field("match_index", 32'(exp_w.match_index), 32'(got.match_index));
    check_field("match_red", 32'(exp_w.match_red), 32'(got.match_red));
    check_field("match_green", 32'(exp_w.match_green), 32'(got.match_green));
    check_field("match_blue", 32'(exp_w.match_blue), 32'(got.match_blue));
    check_field("match_distance", 32'(exp_w.match_distance), 32'(got.match_distance));
    check_field("no_match", 32'(exp_w.no_match), 32'(got.no_match));
  endfunction

  // result side: sample, then pick the next stall value
  always @(posedge clk_i) begin
    if (rst_n && out_valid && !out_stall) check_match(out_word);
    if (stall_left != 0) stall_left--;
    else stall_left = pick_gap(stall_pct);
    out_stall <= (stall_left != 0);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // valid stays high after accept; caller sends again or calls wait_idle in the same step
  task automatic send_word(npcm_pkg::in_word_t w);
    int unsigned gap;
    gap = pick_gap(gap_pct);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_stall);
    if (w.op == npcm_pkg::OP_LOAD) palette_rgb[w.entry_index] = {w.red, w.green, w.blue};
    else pending_matches = {pending_matches, predict_nearest(w)};
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // write with random upper bits, then read back the register field
  task automatic apb_write(npcm_pkg::reg_idx_e r, logic [31:0] v);
    int unsigned width;
    logic [31:0] mask;
    width = (r == npcm_pkg::REG_COUNT) ? npcm_pkg::COUNT_W : npcm_pkg::WEIGHT_W;
    mask  = (32'h1 << width) - 1;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= (v & mask) | ($urandom() & ~mask);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (r)
      npcm_pkg::REG_COUNT: cfg_count = v[npcm_pkg::COUNT_W-1:0];
      npcm_pkg::REG_WR:    cfg_wr    = v[npcm_pkg::WEIGHT_W-1:0];
      npcm_pkg::REG_WG:    cfg_wg    = v[npcm_pkg::WEIGHT_W-1:0];
      npcm_pkg::REG_WB:    cfg_wb    = v[npcm_pkg::WEIGHT_W-1:0];
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("prdata", v & mask, prdata & mask);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_weights(logic [31:0] wr, logic [31:0] wg, logic [31:0] wb);
    apb_write(npcm_pkg::REG_WR, wr);
    apb_write(npcm_pkg::REG_WG, wg);
    apb_write(npcm_pkg::REG_WB, wb);
  endtask

  task automatic test_empty_palette();
    send_word(make_word(npcm_pkg::OP_CLASSIFY, 8'h00, 8'h00, 8'h00, 8'h00));
    send_word(make_word(npcm_pkg::OP_CLASSIFY, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(make_word(npcm_pkg::OP_CLASSIFY, 8'h5A, 8'hAA, 8'h55, 8'hAA));
    wait_idle();
  endtask

  task automatic test_nearest_directed();
    send_word(make_word(npcm_pkg::OP_LOAD, 8'd0, 8'd0, 8'd0, 8'd0));
    send_word(make_word(npcm_pkg::OP_LOAD, 8'd1, 8'd255, 8'd255, 8'd255));
    send_word(make_word(npcm_pkg::OP_LOAD, 8'd2, 8'd128, 8'd128, 8'd128));
    send_word(make_word(npcm_pkg::OP_LOAD, 8'd3, 8'd128, 8'd128, 8'd128));
    send_word(make_word(npcm_pkg::OP_LOAD, 8'd4, 8'd10, 8'd20, 8'd30));
    send_word(make_word(npcm_pkg::OP_LOAD, 8'd5, 8'd20, 8'd20, 8'd30));
    send_word(make_word(npcm_pkg::OP_LOAD, 8'd255, 8'd255, 8'd0, 8'd255));
    wait_idle();
    apb_write(npcm_pkg::REG_COUNT, 6);
    send_word(make_word(npcm_pkg::OP_CLASSIFY, 8'd0, 8'd0, 8'd0, 8'd0));
    send_word(make_word(npcm_pkg::OP_CLASSIFY, 8'd0, 8'd255, 8'd255, 8'd255));
    // duplicate entries: later one wins
    send_word(make_word(npcm_pkg::OP_CLASSIFY, 8'd0, 8'd128, 8'd128, 8'd128));
    // equal distance on either side
    send_word(make_word(npcm_pkg::OP_CLASSIFY, 8'd0, 8'd15, 8'd20, 8'd30));
    send_word(make_word(npcm_pkg::OP_CLASSIFY, 8'd0, 8'd200, 8'd0, 8'd255));
    wait_idle();
  endtask

  task automatic test_weight_extremes();
    set_weights(0, 0, 0);
    send_word(make_word(npcm_pkg::OP_CLASSIFY, 8'd0, 8'd77, 8'd1, 8'd200));
    wait_idle();
    set_weights(1023, 1023, 1023);
    apb_write(npcm_pkg::REG_COUNT, 1);
    // first entry taken even at the largest distance
    send_word(make_word(npcm_pkg::OP_CLASSIFY, 8'd0, 8'd255, 8'd255, 8'd255));
    wait_idle();
    apb_write(npcm_pkg::REG_COUNT, 2);
    send_word(make_word(npcm_pkg::OP_CLASSIFY, 8'd0, 8'd255, 8'd255, 8'd255));
    send_word(make_word(npcm_pkg::OP_CLASSIFY, 8'd0, 8'd0, 8'd0, 8'd0));
    wait_idle();
    set_weights(32'(npcm_pkg::WR_RST), 32'(npcm_pkg::WG_RST), 32'(npcm_pkg::WB_RST));
  endtask

  task automatic test_full_palette();
    npcm_pkg::in_word_t w;
    for (int i = 0; i < npcm_pkg::INDEX_SLOTS; i++) begin
      w = make_word(npcm_pkg::OP_LOAD, i[7:0], 8'($urandom()), 8'($urandom()),
                    8'($urandom()));
      if (i % 16 == 15) {w.red, w.green, w.blue} = palette_rgb[i - 1];
      send_word(w);
    end
    wait_idle();
    apb_write(npcm_pkg::REG_COUNT, 256);
    repeat (4) send_word(make_word(npcm_pkg::OP_CLASSIFY, 8'($urandom()), 8'($urandom()),
                                   8'($urandom()), 8'($urandom())));
    wait_idle();
    // count above the index range saturates
    apb_write(npcm_pkg::REG_COUNT, 511);
    repeat (3) send_word(make_word(npcm_pkg::OP_CLASSIFY, 8'($urandom()), 8'($urandom()),
                                   8'($urandom()), 8'($urandom())));
    wait_idle();
  endtask

  function automatic logic [31:0] random_weight();
    case ($urandom_range(9))
      0: return 0;
      1: return 1023;
      default: return $urandom_range(1023);
    endcase
  endfunction

  task automatic test_random_traffic();
    logic [31:0] count;
    for (int phase = 0; phase < 18; phase++) begin
      wait_idle();
      case ($urandom_range(9))
        0: count = 0;
        1: count = $urandom_range(511, 256);
        default: count = $urandom_range(24, 1);
      endcase
      apb_write(npcm_pkg::REG_COUNT, count);
      set_weights(random_weight(), random_weight(), random_weight());
      gap_pct   = (phase % 4 == 0) ? 0 : $urandom_range(60, 10);
      stall_pct = (phase % 4 == 1) ? 0 : $urandom_range(60, 10);
      repeat (60) send_word(random_word());
    end
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_empty_palette();
    test_nearest_directed();
    test_weight_extremes();
    test_full_palette();
    test_random_traffic();
    wait_idle();
    repeat (300) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
